// ----- sv/rsi_pkg.sv -----
// Shared types and constants for the ray/sphere intersection block.
// No dependencies; every other file in sv/ uses it by scoped names.
package rsi_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [30:0] DIST_SAT     = 31'h7FFFFFFF;
  localparam logic [31:0] MISS_DIST    = 32'hFFFF0000;
  localparam logic [16:0] NORM_ONE     = 17'h10000;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] center;
    logic [30:0]      radius;
  } cfg_t;

  // ray after the front stage: l = origin - center
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [2:0][32:0] l;
    logic             dzero;
  } ray_t;

  // quadratic result handed to the shading pipeline
  typedef struct packed {
    logic             miss;
    logic [30:0]      t_dist;
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
  } trace_t;

  typedef struct packed {
    logic             hit;
    logic [31:0]      distance;
    logic [2:0][31:0] p;
    logic [2:0][17:0] n;
  } result_t;

endpackage

// ----- sv/rsi_front.sv -----
// Input stage: registers an item, forms origin minus center, flags a zero direction.
// Depends on rsi_pkg.
module rsi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [191:0]    s_tdata,
  input  rsi_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output rsi_pkg::ray_t   out_ray
);

  rsi_pkg::ray_t dec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dec.o[i] = s_tdata[32*i +: 32];
      dec.d[i] = s_tdata[96 + 32*i +: 32];
      dec.l[i] = $signed(s_tdata[32*i +: 32]) - $signed(cfg.center[i]);
    end
    dec.dzero = (s_tdata[191:96] == '0);
  end

  assign s_tready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      out_ray <= dec;
    end
  end

endmodule

// ----- sv/rsi_fifo.sv -----
// Short item queue between the front stage and the quadratic pipeline.
// Depends on rsi_pkg.
module rsi_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsi_pkg::ray_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rsi_pkg::ray_t rdata
);

  rsi_pkg::ray_t mem [rsi_pkg::FIFO_DEPTH];
  logic [rsi_pkg::FIFO_AW-1:0] wptr;
  logic [rsi_pkg::FIFO_AW-1:0] rptr;
  logic [rsi_pkg::FIFO_AW:0]   cnt;

  assign full  = (cnt == (rsi_pkg::FIFO_AW+1)'(rsi_pkg::FIFO_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- sv/rsi_quad.sv -----
// Quadratic pipeline: cross products, discriminant, pipelined square root,
// root choice and pipelined divide to the distance. Depends on rsi_pkg.
module rsi_quad (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  rsi_pkg::ray_t   in_ray,
  input  rsi_pkg::cfg_t   cfg,
  output logic            out_valid,
  output rsi_pkg::trace_t out_trace
);

  localparam int SQ_N   = 63;
  localparam int RAD_W  = 2 * SQ_N;
  localparam int SREM_W = SQ_N + 2;
  localparam int DIV_N  = 31;
  localparam int NST    = 7 + SQ_N + 2 + DIV_N;

  typedef struct packed {
    logic               miss;
    logic [2:0][31:0]   o;
    logic [2:0][31:0]   d;
    logic [63:0]        a;
    logic signed [66:0] h;
  } carry_t;

  logic [NST-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld[NST-1];

  // the user must keep the radius static while items are in flight; the block does not enforce it
  logic [61:0] r2;
  always_ff @(posedge clk) begin
    r2 <= cfg.radius * cfg.radius;
  end

  // stage 1: products
  logic [2:0][31:0]   o1;
  logic [2:0][31:0]   d1;
  logic               dz1;
  logic signed [64:0] pa1 [3];
  logic signed [64:0] pb1 [3];
  logic signed [64:0] ph1 [3];
  logic signed [63:0] pd1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      o1  <= in_ray.o;
      d1  <= in_ray.d;
      dz1 <= in_ray.dzero;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_s1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        pa1[i] <= $signed(in_ray.d[J]) * $signed(in_ray.l[K]);
        pb1[i] <= $signed(in_ray.d[K]) * $signed(in_ray.l[J]);
        ph1[i] <= $signed(in_ray.d[i]) * $signed(in_ray.l[i]);
        pd1[i] <= $signed(in_ray.d[i]) * $signed(in_ray.d[i]);
      end
    end
  end

  // stage 2: cross terms, D.L, D.D
  carry_t             c2;
  logic signed [65:0] x2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      c2.miss <= dz1;
      c2.o    <= o1;
      c2.d    <= d1;
      c2.a    <= $unsigned(pd1[0]) + $unsigned(pd1[1]) + $unsigned(pd1[2]);
      c2.h    <= ph1[0] + ph1[1] + ph1[2];
      for (int i = 0; i < 3; i++) begin
        x2[i] <= pa1[i] - pb1[i];
      end
    end
  end

  // stage 3: magnitudes, too-large cross term is a miss
  carry_t      c3;
  carry_t      c3_next;
  logic [62:0] ax3 [3];
  logic [65:0] abs2 [3];
  logic        ovf2;

  always_comb begin
    ovf2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      abs2[i] = x2[i][65] ? $unsigned(-x2[i]) : $unsigned(x2[i]);
      ovf2    = ovf2 | (|abs2[i][65:63]);
    end
    c3_next      = c2;
    c3_next.miss = c2.miss | ovf2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3 <= c3_next;
      for (int i = 0; i < 3; i++) begin
        ax3[i] <= abs2[i][62:0];
      end
    end
  end

  // stage 4: 32-bit partial products
  carry_t      c4;
  logic [61:0] phh4 [3];
  logic [62:0] phl4 [3];
  logic [63:0] pll4 [3];
  logic [61:0] arhh4;
  logic [63:0] arhl4;
  logic [61:0] arlh4;
  logic [63:0] arll4;

  always_ff @(posedge clk) begin
    if (adv) begin
      c4 <= c3;
      for (int i = 0; i < 3; i++) begin
        phh4[i] <= ax3[i][62:32] * ax3[i][62:32];
        phl4[i] <= ax3[i][62:32] * ax3[i][31:0];
        pll4[i] <= ax3[i][31:0] * ax3[i][31:0];
      end
      arhh4 <= c3.a[63:32] * r2[61:32];
      arhl4 <= c3.a[63:32] * r2[31:0];
      arlh4 <= c3.a[31:0] * r2[61:32];
      arll4 <= c3.a[31:0] * r2[31:0];
    end
  end

  // stage 5: squares and A*R^2
  carry_t       c5;
  logic [127:0] sq5 [3];
  logic [127:0] ar5;

  always_ff @(posedge clk) begin
    if (adv) begin
      c5 <= c4;
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= {2'b0, phh4[i], 64'b0} + {32'b0, phl4[i], 33'b0} + {64'b0, pll4[i]};
      end
      ar5 <= {2'b0, arhh4, 64'b0} + {32'b0, arhl4, 32'b0}
           + {34'b0, arlh4, 32'b0} + {64'b0, arll4};
    end
  end

  // stage 6: |D x L|^2
  carry_t       c6;
  logic [127:0] q6;
  logic [127:0] ar6;

  always_ff @(posedge clk) begin
    if (adv) begin
      c6  <= c5;
      q6  <= sq5[0] + sq5[1] + sq5[2];
      ar6 <= ar5;
    end
  end

  // stage 7: discriminant feeds the root pipeline
  logic [RAD_W-1:0]  srad  [SQ_N+1];
  logic [SREM_W-1:0] srem  [SQ_N+1];
  logic [SQ_N-1:0]   sroot [SQ_N+1];
  carry_t            scar  [SQ_N+1];
  carry_t            scar0_next;
  logic [127:0]      disc6;

  assign disc6 = ar6 - q6;

  always_comb begin
    scar0_next      = c6;
    scar0_next.miss = c6.miss | (q6 > ar6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scar[0]  <= scar0_next;
      srad[0]  <= disc6[RAD_W-1:0];
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] tr;
    assign t  = {srem[k], srad[k][RAD_W-1 -: 2]};
    assign tr = {2'b0, sroot[k], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        srad[k+1] <= srad[k] << 2;
        scar[k+1] <= scar[k];
        if (t >= tr) begin
          srem[k+1]  <= SREM_W'(t - tr);
          sroot[k+1] <= {sroot[k][SQ_N-2:0], 1'b1};
        end else begin
          srem[k+1]  <= t[SREM_W-1:0];
          sroot[k+1] <= {sroot[k][SQ_N-2:0], 1'b0};
        end
      end
    end
  end

  // root choice: smaller non-negative root of -H -+ s
  carry_t             carr;
  carry_t             carr_next;
  logic [66:0]        nnr;
  logic signed [67:0] hx;
  logic signed [67:0] n1;
  logic signed [67:0] n2;

  always_comb begin
    hx = scar[SQ_N].h;
    n1 = -hx - $signed({5'b0, sroot[SQ_N]});
    n2 = -hx + $signed({5'b0, sroot[SQ_N]});
    carr_next      = scar[SQ_N];
    carr_next.miss = scar[SQ_N].miss | (n1[67] & n2[67]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carr <= carr_next;
      nnr  <= n1[67] ? n2[66:0] : n1[66:0];
    end
  end

  // divide setup: saturation test and first partial remainder
  logic [63:0]      drem [DIV_N+1];
  logic [DIV_N-1:0] dnb  [DIV_N+1];
  logic [DIV_N-1:0] dq   [DIV_N+1];
  logic             dsat [DIV_N+1];
  carry_t           dcar [DIV_N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dcar[0] <= carr;
      dsat[0] <= {12'b0, nnr[66:15]} >= carr.a;
      drem[0] <= {12'b0, nnr[66:15]};
      dnb[0]  <= {nnr[14:0], 16'b0};
      dq[0]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [64:0] t;
    assign t = {drem[k], dnb[k][DIV_N-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dcar[k+1] <= dcar[k];
        dsat[k+1] <= dsat[k];
        dnb[k+1]  <= dnb[k] << 1;
        if (t >= {1'b0, dcar[k].a}) begin
          drem[k+1] <= 64'(t - {1'b0, dcar[k].a});
          dq[k+1]   <= {dq[k][DIV_N-2:0], 1'b1};
        end else begin
          drem[k+1] <= t[63:0];
          dq[k+1]   <= {dq[k][DIV_N-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    out_trace.miss   = dcar[DIV_N].miss;
    out_trace.t_dist = dsat[DIV_N] ? rsi_pkg::DIST_SAT : dq[DIV_N];
    out_trace.o      = dcar[DIV_N].o;
    out_trace.d      = dcar[DIV_N].d;
  end

endmodule

// ----- sv/rsi_shade.sv -----
// Shading pipeline: hit point, pipelined |P - C| square root, three normal
// dividers and the output register. Depends on rsi_pkg.
module rsi_shade (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  rsi_pkg::trace_t  in_trace,
  input  rsi_pkg::cfg_t    cfg,
  output logic             out_valid,
  output rsi_pkg::result_t out_res
);

  localparam int SQ_N   = 33;
  localparam int RAD_W  = 2 * SQ_N;
  localparam int SREM_W = SQ_N + 2;
  localparam int DIV_N  = 17;
  localparam int NST    = 5 + SQ_N + 1 + DIV_N + 1;

  typedef struct packed {
    logic             miss;
    logic [30:0]      t_dist;
    logic [2:0][31:0] p;
    logic [2:0][32:0] v;
    logic [2:0][32:0] av;
  } carry_t;

  logic [NST-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld[NST-1];

  // stage 1: distance times direction
  logic               m1;
  logic [30:0]        dist1;
  logic [2:0][31:0]   o1;
  logic signed [62:0] prod1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= in_trace.miss;
      dist1 <= in_trace.t_dist;
      o1    <= in_trace.o;
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= $signed({1'b0, in_trace.t_dist}) * $signed(in_trace.d[i]);
      end
    end
  end

  // stage 2: saturated hit point
  logic               m2;
  logic [30:0]        dist2;
  logic [2:0][31:0]   p2;
  logic signed [62:0] psum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = $signed(o1[i]) + (prod1[i] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2    <= m1;
      dist2 <= dist1;
      for (int i = 0; i < 3; i++) begin
        priority if (psum[i] > 63'sd2147483647) p2[i] <= 32'h7FFFFFFF;
        else if (psum[i] < -63'sd2147483648)    p2[i] <= 32'h80000000;
        else                                     p2[i] <= psum[i][31:0];
      end
    end
  end

  // stage 3: V = P - C
  logic               m3;
  logic [30:0]        dist3;
  logic [2:0][31:0]   p3;
  logic signed [32:0] v3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m3    <= m2;
      dist3 <= dist2;
      p3    <= p2;
      for (int i = 0; i < 3; i++) begin
        v3[i] <= $signed(p2[i]) - $signed(cfg.center[i]);
      end
    end
  end

  // stage 4: squares and magnitudes
  carry_t             c4;
  logic signed [65:0] vsq4 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      c4.miss   <= m3;
      c4.t_dist <= dist3;
      c4.p      <= p3;
      for (int i = 0; i < 3; i++) begin
        vsq4[i]  <= v3[i] * v3[i];
        c4.v[i]  <= v3[i];
        c4.av[i] <= v3[i][32] ? $unsigned(-v3[i]) : $unsigned(v3[i]);
      end
    end
  end

  // stage 5: V.V feeds the root pipeline
  logic [RAD_W-1:0]  srad  [SQ_N+1];
  logic [SREM_W-1:0] srem  [SQ_N+1];
  logic [SQ_N-1:0]   sroot [SQ_N+1];
  carry_t            scar  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      scar[0]  <= c4;
      srad[0]  <= $unsigned(vsq4[0]) + $unsigned(vsq4[1]) + $unsigned(vsq4[2]);
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] tr;
    assign t  = {srem[k], srad[k][RAD_W-1 -: 2]};
    assign tr = {2'b0, sroot[k], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        srad[k+1] <= srad[k] << 2;
        scar[k+1] <= scar[k];
        if (t >= tr) begin
          srem[k+1]  <= SREM_W'(t - tr);
          sroot[k+1] <= {sroot[k][SQ_N-2:0], 1'b1};
        end else begin
          srem[k+1]  <= t[SREM_W-1:0];
          sroot[k+1] <= {sroot[k][SQ_N-2:0], 1'b0};
        end
      end
    end
  end

  // normal dividers: |V| * 2^16 / m; the quotient is clamped to 2^16 at the output
  logic [SQ_N-1:0]  dm   [DIV_N+1];
  carry_t           dcar [DIV_N+1];
  logic [SQ_N-1:0]  drem [3][DIV_N+1];
  logic [DIV_N-1:0] dnb  [3][DIV_N+1];
  logic [DIV_N-1:0] dq   [3][DIV_N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dm[0]   <= sroot[SQ_N];
      dcar[0] <= scar[SQ_N];
      for (int i = 0; i < 3; i++) begin
        drem[i][0] <= {1'b0, scar[SQ_N].av[i][32:1]};
        dnb[i][0]  <= {scar[SQ_N].av[i][0], 16'b0};
        dq[i][0]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dm[k+1]   <= dm[k];
        dcar[k+1] <= dcar[k];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_ax
      logic [SQ_N:0] t;
      assign t = {drem[i][k], dnb[i][k][DIV_N-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dnb[i][k+1] <= dnb[i][k] << 1;
          if (t >= {1'b0, dm[k]}) begin
            drem[i][k+1] <= SQ_N'(t - {1'b0, dm[k]});
            dq[i][k+1]   <= {dq[i][k][DIV_N-2:0], 1'b1};
          end else begin
            drem[i][k+1] <= t[SQ_N-1:0];
            dq[i][k+1]   <= {dq[i][k][DIV_N-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output register
  carry_t      cf;
  logic [16:0] nm [3];

  assign cf = dcar[DIV_N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dm[DIV_N] == '0) begin
        nm[i] = '0;
      end else if (dq[i][DIV_N] > rsi_pkg::NORM_ONE) begin
        nm[i] = rsi_pkg::NORM_ONE;
      end else begin
        nm[i] = dq[i][DIV_N];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cf.miss) begin
        out_res.hit      <= 1'b0;
        out_res.distance <= rsi_pkg::MISS_DIST;
        out_res.p        <= '0;
        out_res.n        <= '0;
      end else begin
        out_res.hit      <= 1'b1;
        out_res.distance <= {1'b0, cf.t_dist};
        out_res.p        <= cf.p;
        for (int i = 0; i < 3; i++) begin
          out_res.n[i] <= cf.v[i][32] ? 18'(-{1'b0, nm[i]}) : {1'b0, nm[i]};
        end
      end
    end
  end

endmodule

// ----- sv/ray_sphere_intersect_top.sv -----
// Ray/sphere intersection, top level: config registers, front stage, queue and
// the two arithmetic pipelines. Depends on rsi_pkg, rsi_front, rsi_fifo,
// rsi_quad, rsi_shade.
//
// Accepts one ray per clock while the output is not stalled and returns one
// result per ray, in order. The path from input accept to output valid runs
// through the 63-step discriminant square root, the 31-step distance divider,
// the 33-step |P - C| square root and the 17-step normal dividers, all fully
// pipelined. A stalled output holds the whole back pipeline; a 4-item
// queue plus the front register keep taking input meanwhile. Config
// writes are always ready and should only be issued while the block is idle.
module ray_sphere_intersect_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // distance, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, 2 pad bits
  output logic [183:0] m_tdata,
  // hit
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  rsi_pkg::cfg_t    cfg;
  rsi_pkg::ray_t    front_ray;
  rsi_pkg::ray_t    fifo_ray;
  rsi_pkg::trace_t  trace;
  rsi_pkg::result_t res;
  logic             front_valid;
  logic             fifo_full;
  logic             fifo_empty;
  logic             quad_valid;
  logic             adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= '0;
      cfg.radius <= rsi_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rsi_pkg::reg_idx_t'(cfg_index))
        rsi_pkg::REG_CENTER_X: cfg.center[0] <= cfg_data;
        rsi_pkg::REG_CENTER_Y: cfg.center[1] <= cfg_data;
        rsi_pkg::REG_CENTER_Z: cfg.center[2] <= cfg_data;
        rsi_pkg::REG_RADIUS:   cfg.radius    <= cfg_data[30:0];
      endcase
    end
  end

  assign adv = !m_tvalid || m_tready;

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_ready (!fifo_full),
    .out_ray   (front_ray)
  );

  rsi_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid && !fifo_full),
    .wdata (front_ray),
    .full  (fifo_full),
    .pop   (adv && !fifo_empty),
    .empty (fifo_empty),
    .rdata (fifo_ray)
  );

  rsi_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (!fifo_empty),
    .in_ray    (fifo_ray),
    .cfg       (cfg),
    .out_valid (quad_valid),
    .out_trace (trace)
  );

  rsi_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (quad_valid),
    .in_trace  (trace),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tuser = res.hit;
  assign m_tdata = {2'b0, res.n[2], res.n[1], res.n[0],
                    res.p[2], res.p[1], res.p[0], res.distance};

endmodule
